### rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the 12-bit coefficient pack codec.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

  localparam logic [11:0]        MODULUS       = 12'd3457;
  localparam logic signed [15:0] BARRETT_MUL   = 16'sd19412;
  localparam logic signed [31:0] BARRETT_ROUND = 32'sh0200_0000;
  localparam int                 BARRETT_SHIFT = 26;

  typedef enum logic [1:0] {
    MODE_REDUCE  = 2'd0,
    MODE_PACK    = 2'd1,
    MODE_COMPARE = 2'd2,
    MODE_UNPACK  = 2'd3
  } mode_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the accepted word
    logic adv_mul;   // register the Barrett products
    logic adv_red;   // register the quotient times modulus
    logic load_out;  // finish and load the output register
  } cpc_cmd_t;

endpackage

`default_nettype wire

### rtl/cpc_in_if.sv
// ----------------------------------------------------------------------------
// cpc_in_if
// Input channel: a coefficient pair, wire bytes and the last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coeff_a;
  logic signed [15:0] coeff_b;
  logic [23:0]        packed_in;
  logic               last_in;

  modport source (output valid, output coeff_a, output coeff_b, output packed_in,
                  output last_in, input ready);
  modport sink   (input valid, input coeff_a, input coeff_b, input packed_in,
                  input last_in, output ready);
endinterface

`default_nettype wire

### rtl/cpc_out_if.sv
// ----------------------------------------------------------------------------
// cpc_out_if
// Output channel: packed bytes, decoded values, fail flag and last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] packed_out;
  logic [11:0] value_a;
  logic [11:0] value_b;
  logic        fail;
  logic        last_out;

  modport source (output valid, output packed_out, output value_a, output value_b,
                  output fail, output last_out, input ready);
  modport sink   (input valid, input packed_out, input value_a, input value_b,
                  input fail, input last_out, output ready);
endinterface

`default_nettype wire

### rtl/coeff_12bit_pack_codec.sv
// ----------------------------------------------------------------------------
// coeff_12bit_pack_codec
// Top level: mod-3457 coefficient pair packer, comparator and unpacker.
// ----------------------------------------------------------------------------
// Each accepted word passes through accept, the Barrett multiply by 19412, the
// quotient times 3457 multiply and the final correct/pack step into the output
// register. The controller sequences the two registered multiplications one
// word at a time: a new word waits until the last is in the output register.
// The output register frees the input side: the next word is accepted while a
// finished result still waits, and the final step holds only while the output
// register is occupied. The mode register is written with cfg_we high.
`default_nettype none

module coeff_12bit_pack_codec
  import cpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [1:0] cfg_wdata,
  cpc_in_if.sink     in_ch,
  cpc_out_if.source  out_ch
);

  cpc_cmd_t cmd;

  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cpc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .coeff_a    (in_ch.coeff_a),
    .coeff_b    (in_ch.coeff_b),
    .packed_in  (in_ch.packed_in),
    .last_in    (in_ch.last_in),
    .packed_out (out_ch.packed_out),
    .value_a    (out_ch.value_a),
    .value_b    (out_ch.value_b),
    .fail       (out_ch.fail),
    .last_out   (out_ch.last_out)
  );

endmodule

`default_nettype wire

### rtl/cpc_ctrl.sv
// ----------------------------------------------------------------------------
// cpc_ctrl
// Sequencer: accepts a word, steps it through the two multiply stages and
// loads the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_ctrl
  import cpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cpc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_RED,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && in_valid;
    cmd.adv_mul  = (state == S_MUL);
    cmd.adv_red  = (state == S_RED);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MUL;
        end
        S_MUL:  state <= S_RED;
        S_RED:  state <= S_FIN;
        S_FIN: begin
          // hold until the output register can take the word
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("accepted word did not enter the multiply stage");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while occupied");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("finished word dropped while output stalled");

endmodule

`default_nettype wire

### rtl/cpc_dp.sv
// ----------------------------------------------------------------------------
// cpc_dp
// Datapath: Barrett reduction lanes, packing, unpack check, sticky error flag,
// mode register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_dp
  import cpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpc_cmd_t           cmd,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic signed [15:0] coeff_a,
  input  wire logic signed [15:0] coeff_b,
  input  wire logic [23:0]        packed_in,
  input  wire logic               last_in,
  output logic [23:0]             packed_out,
  output logic [11:0]             value_a,
  output logic [11:0]             value_b,
  output logic                    fail,
  output logic                    last_out
);

  mode_t              mode;
  logic               error_seen;

  logic signed [15:0] a_reg, b_reg;
  logic [23:0]        pk_reg;
  logic               last_reg;
  logic signed [31:0] prod_a, prod_b;
  logic signed [17:0] quot_a, quot_b;

  logic signed [31:0] sum_a, sum_b;
  logic signed [5:0]  t_a, t_b;
  logic               reduce;
  logic [11:0]        can_a, can_b;
  logic [23:0]        packed_w;
  logic [11:0]        dec_a, dec_b;
  logic               flag;
  logic [23:0]        packed_next;
  logic [11:0]        value_a_next, value_b_next;

  // if red, take off the quotient multiple; fold a negative value up by MODULUS
  function automatic logic [11:0] canon12(input logic signed [15:0] a,
                                          input logic signed [17:0] q,
                                          input logic               red);
    logic [17:0] r;
    logic [17:0] rf;
    r  = {{2{a[15]}}, a} - (red ? q : 18'sd0);
    rf = r[17] ? (r + {6'd0, MODULUS}) : r;
    return rf[11:0];
  endfunction

  assign sum_a = prod_a + BARRETT_ROUND;
  assign sum_b = prod_b + BARRETT_ROUND;
  assign t_a   = sum_a[31:BARRETT_SHIFT];
  assign t_b   = sum_b[31:BARRETT_SHIFT];

  assign reduce   = (mode != MODE_PACK);
  assign can_a    = canon12(a_reg, quot_a, reduce);
  assign can_b    = canon12(b_reg, quot_b, reduce);
  assign packed_w = {can_b, can_a};
  assign dec_a    = pk_reg[11:0];
  assign dec_b    = pk_reg[23:12];

  always_comb begin
    unique case (mode) inside
      MODE_REDUCE, MODE_PACK: begin
        packed_next  = packed_w;
        value_a_next = '0;
        value_b_next = '0;
        flag         = 1'b0;
      end
      MODE_COMPARE: begin
        packed_next  = packed_w;
        value_a_next = '0;
        value_b_next = '0;
        flag         = (packed_w != pk_reg);
      end
      MODE_UNPACK: begin
        packed_next  = '0;
        value_a_next = dec_a;
        value_b_next = dec_b;
        flag         = (dec_a >= MODULUS) || (dec_b >= MODULUS);
      end
      default: begin
        packed_next  = '0;
        value_a_next = '0;
        value_b_next = '0;
        flag         = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_REDUCE;
      error_seen <= 1'b0;
    end else begin
      if (cfg_we) mode <= mode_t'(cfg_wdata);
      if (cmd.load_out) begin
        // report and clear on the last word
        error_seen <= last_reg ? 1'b0 : (error_seen || flag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_reg    <= coeff_a;
      b_reg    <= coeff_b;
      pk_reg   <= packed_in;
      last_reg <= last_in;
    end
    if (cmd.adv_mul) begin
      prod_a <= 32'(a_reg) * 32'(BARRETT_MUL);
      prod_b <= 32'(b_reg) * 32'(BARRETT_MUL);
    end
    if (cmd.adv_red) begin
      quot_a <= 18'(t_a) * 18'($signed({1'b0, MODULUS}));
      quot_b <= 18'(t_b) * 18'($signed({1'b0, MODULUS}));
    end
    if (cmd.load_out) begin
      packed_out <= packed_next;
      value_a    <= value_a_next;
      value_b    <= value_b_next;
      fail       <= last_reg && (error_seen || flag);
      last_out   <= last_reg;
    end
  end

endmodule

`default_nettype wire

### tb/coeff_12bit_pack_codec_test.sv
// ----------------------------------------------------------------------------
// coeff_12bit_pack_codec_test
// Self-checking bench for the mod-3457 coefficient pack codec: drives pairs
// through all four modes and predicts every output word (Barrett reduce and
// pack, raw pack, compare against wire bytes, unpack and range check), with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module coeff_12bit_pack_codec_test;
  import cpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [23:0] packed_out;
    logic [11:0] value_a;
    logic [11:0] value_b;
    logic        fail;
    logic        last_out;
  } codec_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();

  coeff_12bit_pack_codec uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  mode_t model_mode;
  logic  model_err;
  codec_word_t expected_words[$];

  int  cycle_count;
  int  error_count;
  int  sent_count;
  int  checked_count;
  int  poly_left;
  bit  no_idle;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [11:0] canon_coeff(input logic signed [15:0] c,
                                              input logic reduce);
    longint prod;
    longint quot;
    int     r;
    r = int'(c);
    if (reduce) begin
      prod = longint'(BARRETT_MUL) * longint'(c) + longint'(BARRETT_ROUND);
      quot = prod >>> BARRETT_SHIFT;
      r    = int'(c) - int'(quot) * int'(MODULUS);
    end
    if (r < 0) r += int'(MODULUS);
    return r[11:0];
  endfunction

  function automatic logic [23:0] packed_reduced(input logic signed [15:0] a, b);
    return {canon_coeff(b, 1'b1), canon_coeff(a, 1'b1)};
  endfunction

  function automatic codec_word_t predict_word(input logic signed [15:0] a, b,
                                               input logic [23:0] pk,
                                               input logic lst);
    codec_word_t w;
    logic        flag;
    w    = '0;
    flag = 1'b0;
    if (model_mode == MODE_UNPACK) begin
      w.value_a = pk[11:0];
      w.value_b = pk[23:12];
      flag      = (pk[11:0] >= MODULUS) || (pk[23:12] >= MODULUS);
    end else begin
      w.packed_out = {canon_coeff(b, model_mode != MODE_PACK),
                      canon_coeff(a, model_mode != MODE_PACK)};
      if (model_mode == MODE_COMPARE) flag = (w.packed_out != pk);
    end
    model_err  = model_err | flag;
    w.fail     = lst & model_err;
    w.last_out = lst;
    if (lst) model_err = 1'b0;
    return w;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] rand_coeff();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom);
    if (r < 7) return 16'(int'($urandom_range(0, 6914)) - 3457);
    if (r < 8) begin
      case ($urandom_range(0, 7))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return -16'sd3457;
        3: return 16'sd3457;
        4: return -16'sd3456;
        5: return 16'sd3456;
        6: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return 16'(int'($urandom_range(0, 200)) - 100);
  endfunction

  function automatic logic [11:0] rand_value();
    if ($urandom_range(0, 19) == 0) return 12'($urandom_range(3457, 4095));
    return 12'($urandom_range(0, 3456));
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_pair(input logic signed [15:0] a, b, input logic [23:0] pk,
                           input logic lst);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.coeff_a   <= a;
    in_ch.coeff_b   <= b;
    in_ch.packed_in <= pk;
    in_ch.last_in   <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_words.push_back(predict_word(a, b, pk, lst));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_mode = m;
  endtask

  task automatic send_random_word();
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [23:0]        pk;
    logic               lst;
    a  = rand_coeff();
    b  = rand_coeff();
    pk = 24'($urandom);
    if (model_mode == MODE_COMPARE) begin
      pk = packed_reduced(a, b);
      if ($urandom_range(0, 9) == 0) pk ^= 24'd1 << $urandom_range(0, 23);
    end else if (model_mode == MODE_UNPACK) begin
      pk = {rand_value(), rand_value()};
    end
    if (poly_left == 0) poly_left = $urandom_range(1, 12);
    poly_left--;
    lst = (poly_left == 0);
    send_pair(a, b, pk, lst);
  endtask

  // ---------------------------------------------------------------- tests

  // mode register left at its reset value
  task automatic test_reset_mode();
    send_pair(16'sd1000, -16'sd1000, 24'h5A5A5A, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 24'hFFFFFF, 1'b1);
  endtask

  task automatic test_reduce_extremes();
    write_mode(MODE_REDUCE);
    send_pair(16'sd0, -16'sd1, 24'h000000, 1'b0);
    send_pair(16'sd3456, 16'sd3457, 24'hFFFFFF, 1'b0);
    send_pair(-16'sd3457, -16'sd3456, 24'h123456, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 24'hABCDEF, 1'b0);
    send_pair(-16'sd32768, 16'sd0, 24'h800001, 1'b0);
    send_pair(-16'sd1, 16'sd1, 24'h000000, 1'b1);
  endtask

  // negative coefficients get 3457 added, then all are truncated to 12 bits
  task automatic test_pack_only();
    write_mode(MODE_PACK);
    send_pair(16'sd3456, -16'sd3456, 24'h000000, 1'b0);
    send_pair(-16'sd1, 16'sd4095, 24'hFFFFFF, 1'b0);
    send_pair(-16'sd32768, 16'sd32767, 24'h000000, 1'b0);
    send_pair(16'sd0, -16'sd3457, 24'hFFFFFF, 1'b1);
  endtask

  task automatic test_compare();
    write_mode(MODE_COMPARE);
    send_pair(16'sd1234, -16'sd2345, packed_reduced(16'sd1234, -16'sd2345), 1'b1);
    send_pair(16'sd32767, 16'sd7, packed_reduced(16'sd32767, 16'sd7), 1'b0);
    send_pair(-16'sd32768, -16'sd1,
              packed_reduced(-16'sd32768, -16'sd1) ^ 24'h800000, 1'b0);
    send_pair(16'sd0, 16'sd3457, packed_reduced(16'sd0, 16'sd3457), 1'b1);
  endtask

  task automatic test_unpack();
    write_mode(MODE_UNPACK);
    send_pair(16'sd5, -16'sd5, {12'd3456, 12'd3456}, 1'b1);
    send_pair(16'sd0, 16'sd0, {12'd3457, 12'd0}, 1'b0);
    send_pair(16'sd0, 16'sd0, {12'd0, 12'd4095}, 1'b1);
    send_pair(-16'sd1, -16'sd1, 24'hFFFFFF, 1'b1);
    send_pair(16'sd0, 16'sd0, 24'h000000, 1'b1);
  endtask

  // a mismatch flagged early in a polynomial survives mode changes
  task automatic test_mode_switch();
    write_mode(MODE_COMPARE);
    send_pair(16'sd100, 16'sd200, packed_reduced(16'sd100, 16'sd200) ^ 24'h000001,
              1'b0);
    write_mode(MODE_REDUCE);
    send_pair(-16'sd100, -16'sd200, 24'h000000, 1'b0);
    write_mode(MODE_PACK);
    send_pair(16'sd300, 16'sd400, 24'h000000, 1'b1);
  endtask

  task automatic test_random_phases();
    mode_t m;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: m = MODE_UNPACK;
        1: m = MODE_REDUCE;
        2: m = MODE_COMPARE;
        3: m = MODE_PACK;
        default: m = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      no_idle = (p == 5);
      repeat (50) send_random_word();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_stall_and_pause();
    write_mode(MODE_COMPARE);
    // hold the output off while words keep coming back to back
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (20) send_random_word();
    no_idle = 1'b0;
    // pause until every result is back, then resume
    wait_drained();
    @(posedge clk);
    repeat (10) send_random_word();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial begin
    int          stall_cnt;
    int          n;
    codec_word_t exp_w;
    stall_cnt    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("output word with no expectation waiting");
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("packed_out", exp_w.packed_out, out_ch.packed_out);
          check_field("value_a", 24'(exp_w.value_a), 24'(out_ch.value_a));
          check_field("value_b", 24'(exp_w.value_b), 24'(out_ch.value_b));
          check_field("fail", 24'(exp_w.fail), 24'(out_ch.fail));
          check_field("last_out", 24'(exp_w.last_out), 24'(out_ch.last_out));
          checked_count++;
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_cnt = HOLD_CYCLES;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        n = idle_len();
        if (n > 0) begin
          stall_cnt    = n - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= MODE_REDUCE;
    in_ch.valid     <= 1'b0;
    in_ch.coeff_a   <= '0;
    in_ch.coeff_b   <= '0;
    in_ch.packed_in <= '0;
    in_ch.last_in   <= 1'b0;
    model_mode    = MODE_REDUCE;
    model_err     = 1'b0;
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    poly_left     = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_mode();
    test_reduce_extremes();
    test_pack_only();
    test_compare();
    test_unpack();
    test_mode_switch();
    test_random_phases();
    test_stall_and_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d coefficient words across reduce, pack, compare and unpack modes,",
             sent_count);
    $display("checked %0d results under random gaps and a long output hold-off.",
             checked_count);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/cpc_pkg.sv
rtl/cpc_in_if.sv
rtl/cpc_out_if.sv
rtl/cpc_ctrl.sv
rtl/cpc_dp.sv
rtl/coeff_12bit_pack_codec.sv
tb/coeff_12bit_pack_codec_test.sv
